[hw/rtl/ecr_pkg.sv]
package ecr_pkg;

  localparam int unsigned MEM_BYTES = 1024;

  localparam int unsigned READ_BIT   = 0;
  localparam int unsigned WRITE_BIT  = 1;
  localparam int unsigned MASTER_BIT = 2;

  localparam logic [2:0]  ARM_TICKS     = 3'd4;
  localparam logic [7:0]  ERASED_BYTE   = 8'hFF;
  localparam logic [23:0] WTIME_RESET   = 24'd54400;
  localparam logic        HIGH_RESET    = 1'b1;

  typedef enum logic [1:0] {
    OP_CTRL = 2'd0,
    OP_TICK = 2'd1,
    OP_LOAD = 2'd2,
    OP_PEEK = 2'd3
  } op_e;

  typedef enum logic {
    CFG_WRITE_TIME = 1'b0,
    CFG_HAS_HIGH   = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

endpackage

[hw/rtl/eeprom_control_register_engine_core.sv]
// an accepted item is registered along with a registered read of the byte store,
// then in ST_EXEC its result goes to the output register and its write-back to the
// byte store happens; it stays in ST_EXEC while a waiting result is stalled, and no
// new item is accepted until it has left ST_EXEC
// reset: control register, countdowns and config go to their reset values, then a
// clearing pass over all MEM_BYTES bytes (1024 by default) writes 0xFF to every byte;
// no item is accepted during that pass, config writes are taken
module eeprom_control_register_engine_core #(
  parameter int unsigned MEM_BYTES = ecr_pkg::MEM_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [23:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  ctrl_value_i,
  input  logic [7:0]  addr_low_i,
  input  logic [7:0]  addr_high_i,
  input  logic [7:0]  data_reg_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  ctrl_out_o,
  output logic        read_valid_o,
  output logic [7:0]  read_data_o,
  output logic        addr_wrapped_o,
  output logic        ready_irq_o,
  output logic        host_error_o
);

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);
  localparam logic [15:0] ADDR_MASK = 16'(MEM_BYTES - 1);
  localparam logic [16:0] MEM_LIMIT = 17'(MEM_BYTES);

  ecr_pkg::state_e state_q, state_d;

  logic [23:0] wtime_q;
  logic        has_high_q;

  logic [7:0]  ctrl_q, ctrl_d;
  logic [2:0]  arm_cnt_q, arm_cnt_d;
  logic [23:0] ready_cnt_q, ready_cnt_d;
  logic [AW-1:0] clr_cnt_q;

  logic [1:0]    op_q;
  logic [7:0]    value_q;
  logic [7:0]    data_q;
  logic [AW-1:0] addr_q;
  logic          oor_q;

  logic        out_valid_q;
  logic [7:0]  ctrl_out_q;
  logic        read_valid_q, read_valid_d;
  logic [7:0]  read_data_q, read_data_d;
  logic        wrapped_q, wrapped_d;
  logic        irq_q, irq_d;
  logic        herr_q, herr_d;

  logic [15:0]   in_addr;
  logic          in_oor;
  logic [15:0]   in_eff;
  logic          accept;
  logic          out_free;
  logic          exec_go;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;
  logic          exec_we;
  logic          old_master;
  logic          wr;
  logic          rd;
  logic [23:0]   wtime_eff;

  // address forming and range check at accept
  assign in_addr = has_high_q ? {addr_high_i, addr_low_i} : {8'h00, addr_low_i};
  assign in_oor  = {1'b0, in_addr} >= MEM_LIMIT;
  assign in_eff  = in_oor ? (in_addr & ADDR_MASK) : in_addr;

  assign in_stall_o = (state_q != ecr_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign exec_go    = (state_q == ecr_pkg::ST_EXEC) && out_free;
  assign wtime_eff  = (wtime_q == 24'd0) ? 24'd1 : wtime_q;

  ecr_ram #(
    .Width (8),
    .Depth (MEM_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_eff[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // item execution
  always_comb begin
    ctrl_d       = ctrl_q;
    arm_cnt_d    = arm_cnt_q;
    ready_cnt_d  = ready_cnt_q;
    read_valid_d = 1'b0;
    read_data_d  = 8'h00;
    wrapped_d    = 1'b0;
    irq_d        = 1'b0;
    herr_d       = 1'b0;
    exec_we      = 1'b0;
    old_master   = ctrl_q[ecr_pkg::MASTER_BIT];
    wr           = old_master && value_q[ecr_pkg::WRITE_BIT];
    rd           = value_q[ecr_pkg::READ_BIT];
    case (ecr_pkg::op_e'(op_q))
      ecr_pkg::OP_CTRL: begin
        ctrl_d = value_q;
        if (!old_master && value_q[ecr_pkg::MASTER_BIT]) begin
          arm_cnt_d = ecr_pkg::ARM_TICKS;
        end
        wrapped_d = (wr || rd) && oor_q;
        if (wr) begin
          exec_we = 1'b1;
          ctrl_d[ecr_pkg::MASTER_BIT] = 1'b0;
          ready_cnt_d = wtime_eff;
        end
        if (rd) begin
          read_valid_d = 1'b1;
          // same-item write lands before the read
          read_data_d  = wr ? data_q : ram_rdata;
        end
        ctrl_d[ecr_pkg::WRITE_BIT] = 1'b0;
        ctrl_d[ecr_pkg::READ_BIT]  = 1'b0;
      end
      ecr_pkg::OP_TICK: begin
        if (arm_cnt_q != 3'd0) begin
          arm_cnt_d = arm_cnt_q - 3'd1;
          if (arm_cnt_q == 3'd1) begin
            ctrl_d[ecr_pkg::MASTER_BIT] = 1'b0;
          end
        end
        if (ready_cnt_q != 24'd0) begin
          ready_cnt_d = ready_cnt_q - 24'd1;
          irq_d       = (ready_cnt_q == 24'd1);
        end
      end
      ecr_pkg::OP_LOAD: begin
        herr_d  = oor_q;
        exec_we = !oor_q;
      end
      ecr_pkg::OP_PEEK: begin
        herr_d      = oor_q;
        read_data_d = oor_q ? 8'h00 : ram_rdata;
      end
      default: begin
        ctrl_d = ctrl_q;
      end
    endcase
  end

  // store write port: clearing pass or item write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = data_q;
    if (state_q == ecr_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = ecr_pkg::ERASED_BYTE;
    end else if (exec_go) begin
      ram_we = exec_we;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ecr_pkg::ST_CLEAR: begin
        if (clr_cnt_q == LAST_ADDR) begin
          state_d = ecr_pkg::ST_IDLE;
        end
      end
      ecr_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = ecr_pkg::ST_EXEC;
        end
      end
      ecr_pkg::ST_EXEC: begin
        if (out_free) begin
          state_d = ecr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ecr_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ecr_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      wtime_q     <= ecr_pkg::WTIME_RESET;
      has_high_q  <= ecr_pkg::HIGH_RESET;
      ctrl_q      <= 8'h00;
      arm_cnt_q   <= 3'd0;
      ready_cnt_q <= 24'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ecr_pkg::ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cfg_we_i) begin
        case (ecr_pkg::cfg_idx_e'(cfg_index_i))
          ecr_pkg::CFG_WRITE_TIME: wtime_q    <= cfg_data_i;
          ecr_pkg::CFG_HAS_HIGH:   has_high_q <= cfg_data_i[0];
          default:                 wtime_q    <= wtime_q;
        endcase
      end
      if (exec_go) begin
        ctrl_q      <= ctrl_d;
        arm_cnt_q   <= arm_cnt_d;
        ready_cnt_q <= ready_cnt_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= opcode_i;
      value_q <= ctrl_value_i;
      data_q  <= data_reg_i;
      addr_q  <= in_eff[AW-1:0];
      oor_q   <= in_oor;
    end
    if (exec_go) begin
      ctrl_out_q   <= ctrl_d;
      read_valid_q <= read_valid_d;
      read_data_q  <= read_data_d;
      wrapped_q    <= wrapped_d;
      irq_q        <= irq_d;
      herr_q       <= herr_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ctrl_out_o     = ctrl_out_q;
  assign read_valid_o   = read_valid_q;
  assign read_data_o    = read_data_q;
  assign addr_wrapped_o = wrapped_q;
  assign ready_irq_o    = irq_q;
  assign host_error_o   = herr_q;

`ifndef ASSERT_OFF
  a_rdata_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ecr_pkg::ST_EXEC && !out_free) |=> $stable(ram_rdata))
    else $error("store read data changed while item waits");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ecr_pkg::ST_EXEC))
    else $error("result raised without an executing item");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ecr_pkg::ST_IDLE) |-> !ram_we)
    else $error("store written with no item in flight");

  a_arm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arm_cnt_q <= ecr_pkg::ARM_TICKS)
    else $error("arm countdown beyond window length");
`endif

endmodule

[hw/rtl/ecr_ram.sv]
module ecr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned AW = $clog2(ecr_pkg::MEM_BYTES);

  typedef struct packed {
    ecr_pkg::op_e op;
    logic [7:0]   ctrl;
    logic [7:0]   alo;
    logic [7:0]   ahi;
    logic [7:0]   data;
  } item_t;

  typedef struct packed {
    logic [7:0] ctrl;
    logic       rvalid;
    logic [7:0] rdata;
    logic       wrapped;
    logic       irq;
    logic       herr;
  } status_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [23:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  opcode;
  logic [7:0]  ctrl_value;
  logic [7:0]  addr_low;
  logic [7:0]  addr_high;
  logic [7:0]  data_reg;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  ctrl_out;
  logic        read_valid;
  logic [7:0]  read_data;
  logic        addr_wrapped;
  logic        ready_irq;
  logic        host_error;

  logic [7:0]  mem_img [0:ecr_pkg::MEM_BYTES-1];
  logic [7:0]  ctrl_q;
  logic [2:0]  arm_q;
  logic [23:0] ready_q;
  logic [23:0] wtime_q;
  logic        high_q;

  status_t     due_status [$];
  int unsigned errors;
  int unsigned cycles;
  int          hold_left;
  bit          idle_on;

  eeprom_control_register_engine_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .opcode_i       (opcode),
    .ctrl_value_i   (ctrl_value),
    .addr_low_i     (addr_low),
    .addr_high_i    (addr_high),
    .data_reg_i     (data_reg),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .ctrl_out_o     (ctrl_out),
    .read_valid_o   (read_valid),
    .read_data_o    (read_data),
    .addr_wrapped_o (addr_wrapped),
    .ready_irq_o    (ready_irq),
    .host_error_o   (host_error)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic status_t eeprom_step(item_t it);
    status_t    r;
    logic [15:0] a;
    logic       old_m;
    logic       wr;
    logic       rd;
    r = '0;
    a = {high_q ? it.ahi : 8'h00, it.alo};
    case (it.op)
      ecr_pkg::OP_CTRL: begin
        old_m = ctrl_q[ecr_pkg::MASTER_BIT];
        wr = old_m && it.ctrl[ecr_pkg::WRITE_BIT];
        rd = it.ctrl[ecr_pkg::READ_BIT];
        ctrl_q = it.ctrl;
        if (!old_m && it.ctrl[ecr_pkg::MASTER_BIT]) arm_q = ecr_pkg::ARM_TICKS;
        if ((wr || rd) && a >= ecr_pkg::MEM_BYTES) begin
          a = a & 16'(ecr_pkg::MEM_BYTES - 1);
          r.wrapped = 1'b1;
        end
        if (wr) begin
          mem_img[a[AW-1:0]] = it.data;
          ctrl_q[ecr_pkg::MASTER_BIT] = 1'b0;
          ready_q = (wtime_q == 24'd0) ? 24'd1 : wtime_q;
        end
        if (rd) begin
          r.rvalid = 1'b1;
          r.rdata = mem_img[a[AW-1:0]];
        end
        ctrl_q[ecr_pkg::WRITE_BIT] = 1'b0;
        ctrl_q[ecr_pkg::READ_BIT] = 1'b0;
      end
      ecr_pkg::OP_TICK: begin
        if (arm_q != 3'd0) begin
          arm_q = arm_q - 3'd1;
          if (arm_q == 3'd0) ctrl_q[ecr_pkg::MASTER_BIT] = 1'b0;
        end
        if (ready_q != 24'd0) begin
          ready_q = ready_q - 24'd1;
          if (ready_q == 24'd0) r.irq = 1'b1;
        end
      end
      ecr_pkg::OP_LOAD: begin
        if (a >= ecr_pkg::MEM_BYTES) r.herr = 1'b1;
        else mem_img[a[AW-1:0]] = it.data;
      end
      default: begin
        if (a >= ecr_pkg::MEM_BYTES) r.herr = 1'b1;
        else r.rdata = mem_img[a[AW-1:0]];
      end
    endcase
    r.ctrl = ctrl_q;
    return r;
  endfunction

  function automatic item_t mk(ecr_pkg::op_e op, logic [7:0] v, logic [15:0] a,
                               logic [7:0] d);
    item_t it;
    it.op = op;
    it.ctrl = v;
    it.ahi = a[15:8];
    it.alo = a[7:0];
    it.data = d;
    return it;
  endfunction

  function automatic logic [15:0] rand_addr();
    logic [15:0] a;
    a[7:0] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 80) a[15:8] = 8'($urandom_range(0, 3));
    else a[15:8] = 8'($urandom_range(0, 255));
    return a;
  endfunction

  function automatic item_t rand_item();
    item_t       it;
    int unsigned r;
    logic [7:0]  v;
    r = $urandom_range(0, 99);
    v = 8'($urandom_range(0, 255));
    if (r < 35) it.op = ecr_pkg::OP_CTRL;
    else if (r < 70) it.op = ecr_pkg::OP_TICK;
    else if (r < 85) it.op = ecr_pkg::OP_LOAD;
    else it.op = ecr_pkg::OP_PEEK;
    r = $urandom_range(0, 99);
    if (r >= 60) v[2:1] = 2'b11;
    else if (r >= 30) v[2:1] = 2'b10;
    it.ctrl = v;
    {it.ahi, it.alo} = rand_addr();
    it.data = 8'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic report(input string what, input int unsigned want, input int unsigned got);
    errors++;
    if (errors <= 50) $display("%0t %s: expected %0h got %0h", $time, what, want, got);
  endtask

  task automatic send_item(item_t it);
    if (idle_on && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= it.op;
    ctrl_value <= it.ctrl;
    addr_low   <= it.alo;
    addr_high  <= it.ahi;
    data_reg   <= it.data;
    do @(posedge clk); while (in_stall);
    due_status.push_back(eeprom_step(it));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_cfg(ecr_pkg::cfg_idx_e idx, logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ecr_pkg::CFG_WRITE_TIME) wtime_q = val;
    else high_q = val[0];
    @(posedge clk);
  endtask

  task automatic write_sequence(output int sent);
    logic [15:0] a;
    logic [7:0]  v;
    int          n;
    a = rand_addr();
    v = 8'($urandom_range(0, 255));
    n = int'($urandom_range(0, 6));
    send_item(mk(ecr_pkg::OP_CTRL, {v[7:3], 3'b100}, a, v));
    send_item(mk(ecr_pkg::OP_CTRL, {v[7:3], 3'b110}, a, 8'($urandom_range(0, 255))));
    repeat (n) send_item(mk(ecr_pkg::OP_TICK, v, a, v));
    send_item(mk(ecr_pkg::OP_CTRL, {v[7:3], 3'b001}, a, v));
    sent = n + 3;
  endtask

  task automatic random_items(int n);
    int k;
    int s;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 99) < 25) begin
        write_sequence(s);
        k += s;
      end else begin
        send_item(rand_item());
        k++;
      end
    end
  endtask

  task automatic test_erased_store();
    send_item(mk(ecr_pkg::OP_PEEK, 8'h00, 16'h0000, 8'h00));
    send_item(mk(ecr_pkg::OP_PEEK, 8'hFF, 16'h03FF, 8'hFF));
    send_item(mk(ecr_pkg::OP_PEEK, 8'h00, 16'hFFFF, 8'h00));
  endtask

  task automatic test_host_access();
    send_item(mk(ecr_pkg::OP_LOAD, 8'h00, 16'h0000, 8'h00));
    send_item(mk(ecr_pkg::OP_LOAD, 8'hFF, 16'h03FF, 8'hA5));
    send_item(mk(ecr_pkg::OP_LOAD, 8'h00, 16'hFFFF, 8'h5A));
    send_item(mk(ecr_pkg::OP_PEEK, 8'h00, 16'h03FF, 8'h00));
  endtask

  task automatic test_register_access();
    send_item(mk(ecr_pkg::OP_CTRL, 8'h04, 16'h0012, 8'h00));
    send_item(mk(ecr_pkg::OP_CTRL, 8'h06, 16'h0012, 8'h3C));
    send_item(mk(ecr_pkg::OP_CTRL, 8'h07, 16'hFC12, 8'h00));
    send_item(mk(ecr_pkg::OP_CTRL, 8'h06, 16'hFFFF, 8'hC3));
    send_item(mk(ecr_pkg::OP_CTRL, 8'hFB, 16'h03FF, 8'hFF));
  endtask

  task automatic test_countdowns();
    settle();
    set_cfg(ecr_pkg::CFG_WRITE_TIME, 24'd2);
    send_item(mk(ecr_pkg::OP_CTRL, 8'h04, 16'h0100, 8'h00));
    send_item(mk(ecr_pkg::OP_CTRL, 8'h06, 16'h0100, 8'h77));
    repeat (2) send_item(mk(ecr_pkg::OP_TICK, 8'h00, 16'h0000, 8'h00));
    send_item(mk(ecr_pkg::OP_CTRL, 8'h04, 16'h0000, 8'h00));
    repeat (4) send_item(mk(ecr_pkg::OP_TICK, 8'h00, 16'h0000, 8'h00));
    settle();
    set_cfg(ecr_pkg::CFG_WRITE_TIME, 24'd0);
    send_item(mk(ecr_pkg::OP_CTRL, 8'h04, 16'h0101, 8'h00));
    send_item(mk(ecr_pkg::OP_CTRL, 8'h06, 16'h0101, 8'h88));
    send_item(mk(ecr_pkg::OP_TICK, 8'h00, 16'h0000, 8'h00));
  endtask

  task automatic test_low_address();
    settle();
    set_cfg(ecr_pkg::CFG_HAS_HIGH, 24'd0);
    send_item(mk(ecr_pkg::OP_PEEK, 8'h00, 16'hFF12, 8'h00));
    send_item(mk(ecr_pkg::OP_CTRL, 8'h01, 16'hFF12, 8'h00));
  endtask

  task automatic test_random_phase(int n, logic [23:0] wt, logic hh, bit idle);
    settle();
    set_cfg(ecr_pkg::CFG_WRITE_TIME, wt);
    set_cfg(ecr_pkg::CFG_HAS_HIGH, {23'd0, hh});
    idle_on = idle;
    random_items(n);
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    settle();
    idle_on = 1'b0;
    hold_left = 300;
    random_items(60);
    idle_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    random_items(20);
    settle();
    random_items(20);
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= idle_on && ($urandom_range(0, 99) < 19);
    end
  end

  always @(posedge clk) begin
    status_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_status.size() == 0) begin
        report("unexpected item", 0, 32'(ctrl_out));
      end else begin
        want = due_status.pop_front();
        if (ctrl_out !== want.ctrl) report("ctrl_out", 32'(want.ctrl), 32'(ctrl_out));
        if (read_valid !== want.rvalid)
          report("read_valid", 32'(want.rvalid), 32'(read_valid));
        if (read_data !== want.rdata) report("read_data", 32'(want.rdata), 32'(read_data));
        if (addr_wrapped !== want.wrapped)
          report("addr_wrapped", 32'(want.wrapped), 32'(addr_wrapped));
        if (ready_irq !== want.irq) report("ready_irq", 32'(want.irq), 32'(ready_irq));
        if (host_error !== want.herr)
          report("host_error", 32'(want.herr), 32'(host_error));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("eeprom_control_register_engine_core: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = ecr_pkg::CFG_WRITE_TIME;
    cfg_data   = '0;
    in_valid   = 1'b0;
    opcode     = ecr_pkg::OP_TICK;
    ctrl_value = '0;
    addr_low   = '0;
    addr_high  = '0;
    data_reg   = '0;
    out_stall  = 1'b0;
    errors     = 0;
    cycles     = 0;
    hold_left  = 0;
    idle_on    = 1'b1;
    for (int i = 0; i < ecr_pkg::MEM_BYTES; i++) mem_img[i] = ecr_pkg::ERASED_BYTE;
    ctrl_q  = '0;
    arm_q   = '0;
    ready_q = '0;
    wtime_q = ecr_pkg::WTIME_RESET;
    high_q  = ecr_pkg::HIGH_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_erased_store();
    test_host_access();
    test_register_access();
    test_countdowns();
    test_low_address();
    test_random_phase(150, 24'd1, 1'b0, 1'b1);
    test_random_phase(150, 24'hFFFFFF, 1'b1, 1'b1);
    test_random_phase(150, 24'($urandom_range(2, 12)), 1'b1, 1'b0);
    test_backpressure();
    test_sender_pause();
    test_random_phase(150, 24'd5, 1'b0, 1'b1);
    test_random_phase(80, 24'($urandom_range(1, 20)), 1'b1, 1'b1);

    settle();
    repeat (8) @(posedge clk);
    if (due_status.size() != 0) report("items left over", 0, due_status.size());
    if (errors == 0) begin
      $display("eeprom_control_register_engine_core: match");
    end else begin
      $display("eeprom_control_register_engine_core: mismatch");
    end
    $finish;
  end

endmodule
